// ----- rtl/tcs_pkg.sv -----
package tcs_pkg;

	// Counter width default for phase and run tick counts
	localparam int COUNT_WIDTH_DEF = 32;

	// Shared multiplier operand width; product is twice this
	localparam int MUL_W  = 27;
	localparam int PROD_W = 2 * MUL_W;

	// floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2^27
	localparam int                 DIV5_SHIFT = 29;
	localparam logic [MUL_W-1:0]   DIV5_MUL   = 27'd107374183;

	// Configuration register indexes
	localparam logic [2:0] REG_RUN_SECONDS    = 3'd0;
	localparam logic [2:0] REG_CYCLE_COUNT    = 3'd1;
	localparam logic [2:0] REG_MAX_TEMP       = 3'd2;
	localparam logic [2:0] REG_LIGHT_GAIN     = 3'd3;
	localparam logic [2:0] REG_TARGET_LUX     = 3'd4;
	localparam logic [2:0] REG_START_LAMP_PWM = 3'd5;

	// Temperature thresholds, tenths of a degree C
	localparam logic signed [11:0] TEMP_HARD_LIMIT = 12'sd1500;
	localparam logic signed [11:0] TEMP_HEAT_READY = 12'sd300;
	localparam logic signed [11:0] TEMP_COOL_DONE  = 12'sd290;
	localparam logic signed [11:0] TEMP_STAB_TRIP  = 12'sd305;

	// Lux tracking dead band (50 lux in Q.8)
	localparam logic signed [25:0] LUX_DEADBAND = 26'sd12800;

	localparam logic [7:0] PWM_FULL    = 8'd255;
	localparam logic [7:0] PWM_FAN_LOW = 8'd150;
	localparam logic [2:0] SETTLE_MAX  = 3'd7;
	localparam logic [2:0] SETTLE_TICKS = 3'd5;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_START_LUX  = 2'd1,
		CMD_START_FULL = 2'd2,
		CMD_STOP       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PREHEAT = 3'd1,
		PH_HEAT    = 3'd2,
		PH_COOL    = 3'd3,
		PH_STAB    = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE   = 2'd0,
		SEQ_EMA    = 2'd1,
		SEQ_TRACK  = 2'd2,
		SEQ_UPDATE = 2'd3
	} seq_t;

endpackage

// ----- rtl/tcs_mul.sv -----
module tcs_mul
	import tcs_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	// Register the product of the selected operands
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/thermal_cycle_sequencer.sv -----
// Heat and cool cycle sequencer driven by one-second ticks. Each item carries a command
// (tick, start lux-target run, start full-power run, stop) and sensor readings; each
// item gives exactly one result showing the lamp and fan duties, the phase, the tick
// counts, the cycle number and the smoothed light level after that item. A tick passes
// from its transfer into the block through the EMA, tracking and update steps to its
// result; start and stop commands go from transfer straight to update. The tick's steps
// are set by the single 27x27 multiplier, used in turn for the gain correction, the EMA
// divide by five and the lamp tracking divide. A new item is taken the cycle after a
// result is registered, so the block takes no new item while one is in flight. Configuration
// writes take effect on the next edge and are meant to be made between items.
module thermal_cycle_sequencer
	import tcs_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic signed [11:0]     tc_temp,
	input  logic signed [11:0]     ir_temp,
	input  logic signed [11:0]     confirm_tc,
	input  logic [15:0]            raw_lux,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             lamp_pwm,
	output logic [7:0]             fan_pwm,
	output logic [2:0]             phase,
	output logic [COUNT_WIDTH-1:0] phase_ticks,
	output logic [COUNT_WIDTH-1:0] run_ticks,
	output logic [14:0]            cycle_number,
	output logic [23:0]            light_level
);

	// configuration registers
	logic [31:0] run_seconds_q;
	logic [14:0] cycle_count_q;
	logic [10:0] max_temp_q;
	logic [15:0] light_gain_q;
	logic [15:0] target_lux_q;
	logic [7:0]  start_lamp_q;

	// sequencer and latched item
	seq_t               seq_q, seq_d;
	cmd_t               cmd_q;
	logic signed [11:0] tc_q, ir_q, conf_q;
	logic               in_xfer;
	logic               commit;
	logic               out_valid_q;

	// shared multiplier
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;

	// light datapath
	logic [23:0]        corr_sat, corr_q;
	logic [MUL_W-1:0]   ema_sum;
	logic [23:0]        ema_div, ns, ns_q;
	logic signed [25:0] lux_err, trk_s;
	logic [25:0]        lamp_scaled;
	logic               trk_upd_q, s_pos_q;
	logic [PROD_W-DIV5_SHIFT-1:0] trk_quot;
	logic [7:0]         lamp_trk;

	// run state
	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] pc_q, pc_d, pc_inc;
	logic [COUNT_WIDTH-1:0] rc_q, rc_d, rc_inc;
	logic [14:0]            cyc_q, cyc_d;
	logic [2:0]             settle_q, settle_d, settle_inc;
	logic [7:0]             lamp_q, lamp_d, fan_q, fan_d;
	logic [23:0]            smooth_q, smooth_d;
	logic                   full_q, full_d;
	logic                   active, over_temp, halt;
	logic signed [11:0]     lim;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_seconds_q <= 32'd60;
			cycle_count_q <= 15'd0;
			max_temp_q    <= 11'd1000;
			light_gain_q  <= 16'd4096;
			target_lux_q  <= 16'd38000;
			start_lamp_q  <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RUN_SECONDS:    run_seconds_q <= cfg_data;
				REG_CYCLE_COUNT:    cycle_count_q <= cfg_data[14:0];
				REG_MAX_TEMP:       max_temp_q    <= cfg_data[10:0];
				REG_LIGHT_GAIN:     light_gain_q  <= cfg_data[15:0];
				REG_TARGET_LUX:     target_lux_q  <= cfg_data[15:0];
				REG_START_LAMP_PWM: start_lamp_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					seq_d = (cmd_t'(cmd) == CMD_TICK) ? SEQ_EMA : SEQ_UPDATE;
				end
			end
			SEQ_EMA:    seq_d = SEQ_TRACK;
			SEQ_TRACK:  seq_d = SEQ_UPDATE;
			SEQ_UPDATE: begin
				if (commit) begin
					seq_d = SEQ_IDLE;
				end
			end
			default:    seq_d = SEQ_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, commit
	always_comb begin
		in_stall = 1'b1;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		commit   = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				in_stall = 1'b0;
				mul_en   = in_valid;
				mul_a    = MUL_W'(raw_lux);
				mul_b    = MUL_W'(light_gain_q);
			end
			SEQ_EMA: begin
				mul_en = 1'b1;
				mul_a  = ema_sum;
				mul_b  = DIV5_MUL;
			end
			SEQ_TRACK: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(trk_s[24:10]);
				mul_b  = DIV5_MUL;
			end
			SEQ_UPDATE: begin
				commit = !(out_valid_q && out_stall);
			end
			default: ;
		endcase
	end

	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// Latch the transferred item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= cmd_t'(cmd);
			tc_q   <= tc_temp;
			ir_q   <= ir_temp;
			conf_q <= confirm_tc;
		end
	end

	tcs_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Gain-corrected lux in Q16.8, saturated, and the EMA numerator
	assign corr_sat = (|prod[31:28]) ? 24'hFF_FFFF : prod[27:4];
	assign ema_sum  = MUL_W'(corr_sat) + MUL_W'({smooth_q, 2'b00});

	// New smoothed level, snapping up from near zero
	assign ema_div = prod[DIV5_SHIFT+23:DIV5_SHIFT];
	assign ns      = (ema_div < 24'd256 && corr_q > 24'd256) ? corr_q : ema_div;

	// Proportional lamp tracking: s = lamp * 5120 + err
	assign lux_err     = $signed({2'b00, target_lux_q, 8'h00}) - $signed({2'b00, ns});
	assign lamp_scaled = 26'({lamp_q, 12'h000}) + 26'({lamp_q, 10'h000});
	assign trk_s       = $signed(lamp_scaled) + lux_err;

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_EMA) begin
			corr_q <= corr_sat;
		end
		if (seq_q == SEQ_TRACK) begin
			ns_q      <= ns;
			trk_upd_q <= (lux_err > LUX_DEADBAND) || (lux_err < -LUX_DEADBAND);
			s_pos_q   <= trk_s > 26'sd0;
		end
	end

	// Clamp the tracked duty to 0..255
	assign trk_quot = prod[PROD_W-1:DIV5_SHIFT];
	always_comb begin
		if (!s_pos_q) begin
			lamp_trk = 8'd0;
		end else if (trk_quot > (PROD_W-DIV5_SHIFT)'(PWM_FULL)) begin
			lamp_trk = PWM_FULL;
		end else begin
			lamp_trk = trk_quot[7:0];
		end
	end

	// Saturating counters and over-temperature check
	assign pc_inc     = (&pc_q) ? pc_q : pc_q + 1'b1;
	assign rc_inc     = (&rc_q) ? rc_q : rc_q + 1'b1;
	assign settle_inc = (settle_q < SETTLE_MAX) ? settle_q + 3'd1 : settle_q;
	assign lim        = $signed({1'b0, max_temp_q});
	assign active     = (phase_q != PH_IDLE) && (phase_q != PH_DONE);
	assign over_temp  = (tc_q > TEMP_HARD_LIMIT || tc_q > lim)
		&& (conf_q > TEMP_HARD_LIMIT || conf_q > lim);
	assign halt       = (cmd_q == CMD_STOP)
		|| (cmd_q == CMD_TICK && ((over_temp && active) || phase_q == PH_DONE));

	// Run state update for one item
	always_comb begin
		phase_d  = phase_q;
		pc_d     = pc_q;
		rc_d     = rc_q;
		cyc_d    = cyc_q;
		settle_d = settle_q;
		lamp_d   = lamp_q;
		fan_d    = fan_q;
		full_d   = full_q;
		smooth_d = smooth_q;
		case (cmd_q)
			CMD_START_LUX, CMD_START_FULL: begin
				phase_d  = PH_PREHEAT;
				pc_d     = '0;
				rc_d     = '0;
				cyc_d    = 15'd1;
				settle_d = 3'd0;
				full_d   = (cmd_q == CMD_START_FULL);
				lamp_d   = (cmd_q == CMD_START_FULL) ? PWM_FULL : start_lamp_q;
			end
			CMD_TICK: begin
				smooth_d = ns_q;
				if (active) begin
					rc_d = rc_inc;
				end
				case (phase_q)
					PH_IDLE: begin
						lamp_d = 8'd0;
						fan_d  = 8'd0;
					end
					PH_PREHEAT: begin
						pc_d  = pc_inc;
						fan_d = 8'd0;
						if (tc_q >= TEMP_HEAT_READY && ir_q >= TEMP_HEAT_READY) begin
							phase_d = PH_HEAT;
							pc_d    = '0;
						end
					end
					PH_HEAT: begin
						pc_d   = pc_inc;
						fan_d  = 8'd0;
						lamp_d = full_q ? PWM_FULL : (trk_upd_q ? lamp_trk : lamp_q);
						if (32'(pc_inc) >= run_seconds_q) begin
							lamp_d  = 8'd0;
							phase_d = PH_COOL;
							pc_d    = '0;
						end
					end
					PH_COOL: begin
						pc_d   = pc_inc;
						lamp_d = 8'd0;
						fan_d  = PWM_FULL;
						if (tc_q <= TEMP_COOL_DONE && ir_q <= TEMP_COOL_DONE) begin
							phase_d  = PH_STAB;
							settle_d = 3'd0;
							pc_d     = '0;
						end
					end
					PH_STAB: begin
						pc_d     = pc_inc;
						lamp_d   = 8'd0;
						fan_d    = PWM_FAN_LOW;
						settle_d = settle_inc;
						if (tc_q > TEMP_STAB_TRIP) begin
							phase_d = PH_COOL;
							pc_d    = '0;
						end else if (settle_inc >= SETTLE_TICKS) begin
							if (cyc_q >= cycle_count_q) begin
								phase_d = PH_DONE;
							end else begin
								cyc_d   = cyc_q + 15'd1;
								phase_d = PH_PREHEAT;
								pc_d    = '0;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		// Drop the run on stop, confirmed overheat or after done
		if (halt) begin
			phase_d  = PH_IDLE;
			pc_d     = '0;
			rc_d     = '0;
			cyc_d    = 15'd0;
			settle_d = 3'd0;
			lamp_d   = 8'd0;
			fan_d    = 8'd0;
		end
	end

	// Commit the run state once the output slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pc_q     <= '0;
			rc_q     <= '0;
			cyc_q    <= 15'd0;
			settle_q <= 3'd0;
			lamp_q   <= 8'd0;
			fan_q    <= 8'd0;
			smooth_q <= 24'd0;
			full_q   <= 1'b0;
		end else if (commit) begin
			phase_q  <= phase_d;
			pc_q     <= pc_d;
			rc_q     <= rc_d;
			cyc_q    <= cyc_d;
			settle_q <= settle_d;
			lamp_q   <= lamp_d;
			fan_q    <= fan_d;
			smooth_q <= smooth_d;
			full_q   <= full_d;
		end
	end

	// Present a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= commit || (out_valid_q && out_stall);
		end
	end

	assign out_valid    = out_valid_q;
	assign lamp_pwm     = lamp_q;
	assign fan_pwm      = fan_q;
	assign phase        = phase_q;
	assign phase_ticks  = pc_q;
	assign run_ticks    = rc_q;
	assign cycle_number = cyc_q;
	assign light_level  = smooth_q;

`ifndef SYNTH
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(seq_q == SEQ_UPDATE))
		else $error("result raised outside the update step");

	a_phase_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != $past(phase_q)) |-> $past(commit))
		else $error("phase changed without a commit");

	a_idle_no_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (cyc_q == 15'd0))
		else $error("cycle number and idle phase disagree");

	a_idle_outputs_off: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (lamp_q == 8'd0 && fan_q == 8'd0))
		else $error("lamp or fan driven while idle");
`endif

endmodule

// ----- tb/tcs_tb_pkg.sv -----
`timescale 1ns / 100ps

package tcs_tb_pkg;
	import tcs_pkg::*;

	// Counter width used for the block under test
	localparam int TB_COUNT_W = 16;

	// Indexes with no register behind them
	localparam logic [2:0] REG_NONE_LO = 3'd6;
	localparam logic [2:0] REG_NONE_HI = 3'd7;

	// Temperature thresholds in tenths of a degree
	localparam int HOT_LIMIT   = 1500;
	localparam int READY_TEMP  = 300;
	localparam int COOLED_TEMP = 290;
	localparam int RETRIP_TEMP = 305;

	localparam longint LUX_BAND   = 12800;
	localparam longint DUTY_STEP  = 5120;
	localparam logic [7:0] DUTY_FULL = 8'd255;
	localparam logic [7:0] FAN_SLOW  = 8'd150;
	localparam logic [2:0] SETTLE_LIMIT = 3'd7;
	localparam logic [2:0] SETTLE_DONE  = 3'd5;

	typedef struct {
		logic [7:0]            lamp;
		logic [7:0]            fan;
		phase_t                stage;
		logic [TB_COUNT_W-1:0] stage_ticks;
		logic [TB_COUNT_W-1:0] total_ticks;
		logic [14:0]           cycle;
		logic [23:0]           light;
	} cycle_status_t;

	class cycle_scoreboard;
		// register copies
		logic [31:0] heat_secs;
		logic [14:0] cycles_goal;
		logic [10:0] temp_limit;
		logic [15:0] lux_gain;
		logic [15:0] lux_goal;
		logic [7:0]  start_duty;

		// sequencer state
		phase_t                stage;
		logic [TB_COUNT_W-1:0] stage_ticks;
		logic [TB_COUNT_W-1:0] total_ticks;
		logic [14:0]           cycle_no;
		logic [2:0]            settle_ticks;
		logic [7:0]            lamp_duty;
		logic [7:0]            fan_duty;
		logic [23:0]           light_avg;
		bit                    full_drive;

		cycle_status_t status_due[$];
		int errors;
		int checked;
		int runs_done;
		int trips;

		function new();
			heat_secs = 32'd60;
			cycles_goal = 15'd0;
			temp_limit = 11'd1000;
			lux_gain = 16'd4096;
			lux_goal = 16'd38000;
			start_duty = 8'd255;
			halt();
			light_avg = '0;
			full_drive = 1'b0;
			errors = 0;
			checked = 0;
			runs_done = 0;
			trips = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_RUN_SECONDS:    heat_secs = data;
				REG_CYCLE_COUNT:    cycles_goal = data[14:0];
				REG_MAX_TEMP:       temp_limit = data[10:0];
				REG_LIGHT_GAIN:     lux_gain = data[15:0];
				REG_TARGET_LUX:     lux_goal = data[15:0];
				REG_START_LAMP_PWM: start_duty = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [TB_COUNT_W-1:0] count_up(logic [TB_COUNT_W-1:0] c);
			return (&c) ? c : c + 1'b1;
		endfunction

		function void halt();
			stage = PH_IDLE;
			cycle_no = '0;
			stage_ticks = '0;
			total_ticks = '0;
			settle_ticks = '0;
			lamp_duty = '0;
			fan_duty = '0;
		endfunction

		function void begin_run(bit full);
			stage_ticks = '0;
			total_ticks = '0;
			cycle_no = 15'd1;
			settle_ticks = '0;
			full_drive = full;
			lamp_duty = full ? DUTY_FULL : start_duty;
			stage = PH_PREHEAT;
		endfunction

		// Gain-correct the raw reading, then average with weight one fifth
		function void smooth_light(logic [15:0] raw);
			logic [31:0] prod;
			logic [23:0] corr;
			logic [26:0] sum;
			prod = 32'(raw) * 32'(lux_gain);
			corr = (prod[31:28] != 4'd0) ? 24'hFF_FFFF : prod[27:4];
			sum = 27'(corr) + {1'b0, light_avg, 2'b00};
			light_avg = 24'(sum / 27'd5);
			if (light_avg < 24'd256 && corr > 24'd256)
				light_avg = corr;
		endfunction

		// Proportional lamp tracking outside the dead band
		function void track_light();
			longint err;
			longint s;
			if (full_drive) begin
				lamp_duty = DUTY_FULL;
				return;
			end
			err = lux_goal;
			err = err * 256 - longint'(light_avg);
			if (err > LUX_BAND || err < -LUX_BAND) begin
				s = lamp_duty;
				s = s * DUTY_STEP + err;
				if (s <= 0)
					lamp_duty = '0;
				else if (s / DUTY_STEP > 255)
					lamp_duty = DUTY_FULL;
				else
					lamp_duty = 8'(s / DUTY_STEP);
			end
		endfunction

		function void run_phase(int t, int i);
			case (stage)
				PH_PREHEAT: begin
					stage_ticks = count_up(stage_ticks);
					fan_duty = '0;
					if (t >= READY_TEMP && i >= READY_TEMP) begin
						stage = PH_HEAT;
						stage_ticks = '0;
					end
				end
				PH_HEAT: begin
					stage_ticks = count_up(stage_ticks);
					track_light();
					fan_duty = '0;
					if (32'(stage_ticks) >= heat_secs) begin
						lamp_duty = '0;
						stage = PH_COOL;
						stage_ticks = '0;
					end
				end
				PH_COOL: begin
					stage_ticks = count_up(stage_ticks);
					lamp_duty = '0;
					fan_duty = DUTY_FULL;
					if (t <= COOLED_TEMP && i <= COOLED_TEMP) begin
						stage = PH_STAB;
						settle_ticks = '0;
						stage_ticks = '0;
					end
				end
				PH_STAB: begin
					stage_ticks = count_up(stage_ticks);
					lamp_duty = '0;
					fan_duty = FAN_SLOW;
					if (settle_ticks < SETTLE_LIMIT)
						settle_ticks = settle_ticks + 1'b1;
					if (t > RETRIP_TEMP) begin
						stage = PH_COOL;
						stage_ticks = '0;
					end else if (settle_ticks >= SETTLE_DONE) begin
						if (cycle_no >= cycles_goal) begin
							stage = PH_DONE;
							runs_done++;
						end else begin
							cycle_no = cycle_no + 1'b1;
							stage = PH_PREHEAT;
							stage_ticks = '0;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void tick(int t, int i, int f, logic [15:0] raw);
			int lim;
			bit active;
			smooth_light(raw);
			active = stage != PH_IDLE && stage != PH_DONE;
			if (active)
				total_ticks = count_up(total_ticks);
			lim = temp_limit;
			if ((t > HOT_LIMIT || t > lim) && (f > HOT_LIMIT || f > lim) && active) begin
				halt();
				trips++;
			end
			if (stage == PH_DONE) begin
				halt();
			end else if (stage == PH_IDLE) begin
				lamp_duty = '0;
				fan_duty = '0;
			end else begin
				run_phase(t, i);
			end
		endfunction

		// Note an accepted transfer and queue the status it should produce
		function void take_item(cmd_t c, logic signed [11:0] t, logic signed [11:0] i,
				logic signed [11:0] f, logic [15:0] raw);
			cycle_status_t s;
			case (c)
				CMD_START_LUX:  begin_run(1'b0);
				CMD_START_FULL: begin_run(1'b1);
				CMD_STOP:       halt();
				default:        tick(t, i, f, raw);
			endcase
			s.lamp = lamp_duty;
			s.fan = fan_duty;
			s.stage = stage;
			s.stage_ticks = stage_ticks;
			s.total_ticks = total_ticks;
			s.cycle = cycle_no;
			s.light = light_avg;
			status_due.push_back(s);
		endfunction

		function void note_diff(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 10)
					$display("%0t result %0d: %s expected %0d, got %0d",
						$time, checked, name, want, got);
			end
		endfunction

		function void check_status(logic [7:0] lamp, logic [7:0] fan, logic [2:0] ph,
				logic [TB_COUNT_W-1:0] pt, logic [TB_COUNT_W-1:0] rt,
				logic [14:0] cyc, logic [23:0] light);
			cycle_status_t want;
			if (status_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t result with no transfer outstanding", $time);
				return;
			end
			want = status_due.pop_front();
			checked++;
			note_diff("lamp_pwm", want.lamp, lamp);
			note_diff("fan_pwm", want.fan, fan);
			note_diff("phase", want.stage, ph);
			note_diff("phase_ticks", want.stage_ticks, pt);
			note_diff("run_ticks", want.total_ticks, rt);
			note_diff("cycle_number", want.cycle, cyc);
			note_diff("light_level", want.light, light);
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		function bit failed();
			return errors != 0 || status_due.size() != 0;
		endfunction
	endclass

endpackage

// ----- tb/thermal_cycle_sequencer_test.sv -----
`timescale 1ns / 100ps

module thermal_cycle_sequencer_test
	import tcs_pkg::*, tcs_tb_pkg::*;
();

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 180;
	localparam int HOLD_CYCLES   = 100;
	localparam int HEAT_TICKS    = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [31:0]           cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            cmd;
	logic signed [11:0]    tc_temp;
	logic signed [11:0]    ir_temp;
	logic signed [11:0]    confirm_tc;
	logic [15:0]           raw_lux;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            lamp_pwm;
	logic [7:0]            fan_pwm;
	logic [2:0]            phase;
	logic [TB_COUNT_W-1:0] phase_ticks;
	logic [TB_COUNT_W-1:0] run_ticks;
	logic [14:0]           cycle_number;
	logic [23:0]           light_level;

	cycle_scoreboard sb;
	int tx_pct = 0;
	int rx_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	logic [15:0] lux_base = 16'd0;

	thermal_cycle_sequencer #(
		.COUNT_WIDTH(TB_COUNT_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.tc_temp(tc_temp),
		.ir_temp(ir_temp),
		.confirm_tc(confirm_tc),
		.raw_lux(raw_lux),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lamp_pwm(lamp_pwm),
		.fan_pwm(fan_pwm),
		.phase(phase),
		.phase_ticks(phase_ticks),
		.run_ticks(run_ticks),
		.cycle_number(cycle_number),
		.light_level(light_level)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver stall: a requested hold-off first, random stalls otherwise
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_status(lamp_pwm, fan_pwm, phase, phase_ticks, run_ticks,
				cycle_number, light_level);
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", sb.pending());
		$display("Verification failed");
		$finish;
	end

	function automatic logic signed [11:0] temp_in(int lo, int hi);
		return 12'(lo + int'($urandom_range(hi - lo)));
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, data);
	endtask

	// Offer one item after any idle gap and hold it until the transfer
	task automatic send_item(cmd_t c, logic signed [11:0] t, logic signed [11:0] i,
			logic signed [11:0] f, logic [15:0] lux);
		@(negedge clk);
		while ($urandom_range(99) < tx_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		tc_temp = t;
		ir_temp = i;
		confirm_tc = f;
		raw_lux = lux;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_item(c, t, i, f, lux);
		items_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_mode(int m);
		case (m)
			1:       begin tx_pct = 59; rx_pct = 0;  end
			2:       begin tx_pct = 0;  rx_pct = 59; end
			3:       begin tx_pct = 28; rx_pct = 28; end
			default: begin tx_pct = 0;  rx_pct = 0;  end
		endcase
	endtask

	// Rotate through register settings; odd phases add noise above each field narrower than 32 bits
	task automatic apply_settings(int k);
		logic [31:0] junk;
		junk = $urandom() & {32{k[0]}};
		write_reg(REG_RUN_SECONDS, (k % 8 == 7) ? 32'hFFFF_FFFF :
			(k % 4 == 0) ? 32'd0 : (k % 4 == 1) ? 32'd1 : 32'($urandom_range(12, 2)));
		write_reg(REG_CYCLE_COUNT, {junk[31:15], (k % 5 == 1) ? 15'h7FFF :
			(k % 5 == 0) ? 15'd0 : 15'($urandom_range(3, 1))});
		write_reg(REG_MAX_TEMP, {junk[31:11], (k % 3 == 0) ? 11'd500 :
			(k % 3 == 1) ? 11'd2000 : 11'($urandom_range(2047, 500))});
		write_reg(REG_LIGHT_GAIN, {junk[31:16], (k % 4 == 0) ? 16'd1 :
			(k % 4 == 1) ? 16'hFFFF : (k % 4 == 2) ? 16'd4096 : 16'($urandom())});
		write_reg(REG_TARGET_LUX, {junk[31:16], (k % 3 == 0) ? 16'd0 :
			(k % 3 == 1) ? 16'hFFFF : 16'($urandom())});
		write_reg(REG_START_LAMP_PWM, {junk[31:8], (k % 3 == 0) ? 8'd0 :
			(k % 3 == 1) ? 8'hFF : 8'($urandom())});
		write_reg(REG_NONE_LO, $urandom());
		write_reg(REG_NONE_HI, $urandom());
		lux_base = sb.lux_goal + 16'($urandom_range(400)) - 16'd200;
	endtask

	// Steer temperatures so most runs progress, with commands and noise mixed in
	task automatic random_item();
		int r;
		cmd_t c;
		logic signed [11:0] t;
		logic signed [11:0] i;
		logic signed [11:0] f;
		logic [15:0] lux;
		r = $urandom_range(99);
		c = CMD_TICK;
		if (sb.stage == PH_IDLE) begin
			if (r < 35)
				c = CMD_START_LUX;
			else if (r < 50)
				c = CMD_START_FULL;
			else if (r < 53)
				c = CMD_STOP;
		end else if (r < 1) begin
			c = CMD_START_LUX;
		end else if (r < 2) begin
			c = CMD_START_FULL;
		end else if (r < 3) begin
			c = CMD_STOP;
		end
		f = temp_in(-400, 1400);
		case (sb.stage)
			PH_PREHEAT: begin t = temp_in(290, 330); i = temp_in(295, 330); end
			PH_COOL:    begin t = temp_in(260, 300); i = temp_in(260, 295); end
			PH_STAB:    begin t = temp_in(270, 308); i = temp_in(200, 400); end
			default:    begin t = temp_in(200, 400); i = temp_in(200, 400); end
		endcase
		r = $urandom_range(99);
		if (r < 8) begin
			t = 12'($urandom());
			i = 12'($urandom());
			f = 12'($urandom());
		end else if (r < 11) begin
			t = temp_in(450, 2047);
			f = temp_in(450, 2047);
		end
		lux = ($urandom_range(1) != 0) ? 16'($urandom()) :
			16'(lux_base + $urandom_range(128) - 64);
		send_item(c, t, i, f, lux);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		tc_temp = '0;
		ir_temp = '0;
		confirm_tc = '0;
		raw_lux = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: one complete short cycle plus restarts, stop and a trip
		set_mode(0);
		write_reg(REG_RUN_SECONDS, 32'd2);
		write_reg(REG_CYCLE_COUNT, 32'd1);
		write_reg(REG_MAX_TEMP, 32'd2000);
		write_reg(REG_LIGHT_GAIN, 32'hFFFF);
		write_reg(REG_TARGET_LUX, 32'hFFFF);
		write_reg(REG_START_LAMP_PWM, 32'd0);
		write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
		write_reg(REG_NONE_HI, 32'h1234_5678);
		send_item(CMD_TICK, -12'sd400, -12'sd400, -12'sd400, 16'hFFFF);
		send_item(CMD_TICK, 12'sd2047, 12'sd2047, 12'sd2047, 16'h0000);
		send_item(CMD_START_LUX, 12'sd0, 12'sd0, 12'sd0, 16'd1000);
		send_item(CMD_TICK, 12'sd300, 12'sd299, 12'sd0, 16'd40000);
		send_item(CMD_TICK, 12'sd300, 12'sd300, 12'sd0, 16'd40000);
		send_item(CMD_TICK, 12'sd350, 12'sd350, 12'sd0, 16'd100);
		send_item(CMD_START_FULL, 12'sd0, 12'sd0, 12'sd0, 16'd100);
		send_item(CMD_TICK, 12'sd2000, 12'sd2000, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd400, 12'sd400, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd400, 12'sd400, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd291, 12'sd200, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd290, 12'sd290, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd306, 12'sd250, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd100, 12'sd100, 12'sd0, 16'd500);
		repeat (5) send_item(CMD_TICK, 12'sd305, 12'sd250, 12'sd0, 16'd500);
		send_item(CMD_TICK, 12'sd250, 12'sd250, 12'sd0, 16'd500);
		send_item(CMD_START_LUX, 12'sd0, 12'sd0, 12'sd0, 16'd0);
		send_item(CMD_TICK, 12'sd2000, 12'sd2000, 12'sd1600, 16'd0);
		send_item(CMD_START_FULL, 12'sd0, 12'sd0, 12'sd0, 16'd0);
		send_item(CMD_STOP, 12'sd0, 12'sd0, 12'sd0, 16'd0);
		send_item(CMD_TICK, -12'sd2048, 12'sd2047, -12'sd1, 16'h8000);

		// Hold a full-power heat phase for a stretch of ticks
		drain();
		write_reg(REG_RUN_SECONDS, 32'hFFFF_FFFF);
		send_item(CMD_START_FULL, 12'sd0, 12'sd0, 12'sd0, 16'd0);
		send_item(CMD_TICK, 12'sd300, 12'sd300, 12'sd0, 16'd0);
		repeat (HEAT_TICKS)
			send_item(CMD_TICK, 12'sd250, 12'sd250, 12'sd0, 16'($urandom()));
		send_item(CMD_STOP, 12'sd0, 12'sd0, 12'sd0, 16'd0);

		// Random phases, each under fresh settings and one of four idling patterns
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			drain();
			apply_settings(k);
			set_mode(k % 4);
			if (k == 0)
				hold_asked++;
			repeat (PHASE_ITEMS) random_item();
		end
		drain();

		$display("%0d transfers in, %0d results checked: directed cycle, full-power heat hold,",
			items_sent, sb.checked);
		$display("%0d random setting phases; %0d runs reached done, %0d over-temperature stops",
			RANDOM_PHASES, sb.runs_done, sb.trips);
		if (sb.errors != 0)
			$display("%0d field mismatches", sb.errors);
		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		if (sb.failed()) begin
			$display("Verification failed");
		end else begin
			$display("Verification passed");
		end
		$finish;
	end

endmodule
